/* hw/rtl/owb_pkg.sv */
package owb_pkg;

    // Opcode carried with every input transaction.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // Bus sequencer phases.
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_WAIT  = 4'd2,
        PH_PRES_FALL = 4'd3,
        PH_PRES_RISE = 4'd4,
        PH_WR_LOW    = 4'd5,
        PH_WR_SLOT   = 4'd6,
        PH_WR_REL    = 4'd7,
        PH_WR_RECOV  = 4'd8,
        PH_RD_PULSE  = 4'd9,
        PH_RD_DELAY  = 4'd10,
        PH_RD_SLOT   = 4'd11
    } phase_t;

    localparam int CfgAddrWidth = 3;
    localparam int CfgDataWidth = 10;
    localparam int TickWidth    = 10;
    localparam int BitIdxWidth  = 4;
    localparam int ByteWidth    = 8;

    // Configuration register indexes.
    localparam logic [CfgAddrWidth-1:0] CFG_RESET_LOW_TIME     = 3'd0;
    localparam logic [CfgAddrWidth-1:0] CFG_PRESENCE_WAIT_TIME = 3'd1;
    localparam logic [CfgAddrWidth-1:0] CFG_WRITE_LOW_TIME     = 3'd2;
    localparam logic [CfgAddrWidth-1:0] CFG_SLOT_TIME          = 3'd3;
    localparam logic [CfgAddrWidth-1:0] CFG_SAMPLE_DELAY       = 3'd4;
    localparam logic [CfgAddrWidth-1:0] CFG_RECOVERY_TIME      = 3'd5;

    // Reset values of the timing registers, in microseconds.
    localparam logic [9:0] RESET_LOW_TIME_DEF     = 10'd600;
    localparam logic [7:0] PRESENCE_WAIT_TIME_DEF = 8'd60;
    localparam logic [3:0] WRITE_LOW_TIME_DEF     = 4'd1;
    localparam logic [7:0] SLOT_TIME_DEF          = 8'd50;
    localparam logic [5:0] SAMPLE_DELAY_DEF       = 6'd5;
    localparam logic [7:0] RECOVERY_TIME_DEF      = 8'd50;

    localparam logic [BitIdxWidth-1:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [7:0] presence_wait_time;
        logic [3:0] write_low_time;
        logic [7:0] slot_time;
        logic [5:0] sample_delay;
        logic [7:0] recovery_time;
    } owb_cfg_t;

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic                 rejected;
        logic [ByteWidth-1:0] read_data;
        logic                 done_res;
        logic                 busy_res;
        logic                 drive_low;
    } owb_res_t;

    localparam int ResWidth   = $bits(owb_res_t);
    localparam int MDataWidth = ((ResWidth + 7) / 8) * 8;
    localparam int SDataWidth = ((ByteWidth + 1 + 7) / 8) * 8;

endpackage

/* hw/rtl/one_wire_byte_master_unit.sv */
// Channel   | Direction | Payload
// ----------+-----------+--------------------------------------------------------
// s_ (item) | in        | tuser: opcode; tdata: write_data, line_level
// m_ (res)  | out       | tdata: drive_low, busy_res, done_res, read_data, rejected
// cfg_      | in        | write enable, register index, write data (no read-back)
//
// One item is accepted every cycle while s_tready is high; its result is offered from the output register.
// The input register feeds the sequencer step, whose result lands in the output register.
// Reset (synchronous, aresetn low) restores default timings and an idle sequencer.
// While the result waits for m_tready, one more item can sit in the input register.
module one_wire_byte_master_unit
    import owb_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    // Input item channel.
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [SDataWidth-1:0]   s_tdata,   // [7:0] write_data, [8] line_level
    input  logic [1:0]              s_tuser,   // [1:0] opcode

    // Result channel.
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [MDataWidth-1:0]   m_tdata,   // [0] drive_low, [1] busy_res,
                                               // [2] done_res, [10:3] read_data,
                                               // [11] rejected

    // Configuration write port.
    input  logic                    cfg_we,
    input  logic [CfgAddrWidth-1:0] cfg_addr,
    input  logic [CfgDataWidth-1:0] cfg_wdata
);

    owb_cfg_t cfg;
    owb_res_t res;

    // Input register.
    logic                 in_valid_reg, in_valid_next;
    logic [1:0]           in_op_reg;
    logic [ByteWidth-1:0] in_data_reg;
    logic                 in_lvl_reg;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    owb_res_t             out_res_reg;

    logic out_free;
    logic advance;
    logic in_take;

    // The output register can take a result when empty or being drained this cycle.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    always_comb begin
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_op_reg   <= s_tuser;
            in_data_reg <= s_tdata[ByteWidth-1:0];
            in_lvl_reg  <= s_tdata[ByteWidth];
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    owb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The sequencer state moves exactly once per transaction, when it advances.
    owb_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .step       (advance),
        .opcode     (in_op_reg),
        .write_data (in_data_reg),
        .line_level (in_lvl_reg),
        .res        (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(MDataWidth - ResWidth){1'b0}}, out_res_reg};

    // A held input item keeps its payload until it moves on.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=>
            (in_valid_reg && $stable(in_op_reg) && $stable(in_data_reg) && $stable(in_lvl_reg)))
        else $error("input register lost a pending item");

    // Every step produces a result on the output side.
    a_step_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("sequencer step produced no result");

    // A result that is not taken stays offered with the same payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("waiting result changed before it was taken");

endmodule

/* hw/rtl/owb_cfg.sv */
module owb_cfg
    import owb_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CfgAddrWidth-1:0] cfg_addr,
    input  logic [CfgDataWidth-1:0] cfg_wdata,
    output owb_cfg_t                cfg
);

    owb_cfg_t cfg_reg;
    owb_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_RESET_LOW_TIME:     cfg_next.reset_low_time     = cfg_wdata[9:0];
                CFG_PRESENCE_WAIT_TIME: cfg_next.presence_wait_time = cfg_wdata[7:0];
                CFG_WRITE_LOW_TIME:     cfg_next.write_low_time     = cfg_wdata[3:0];
                CFG_SLOT_TIME:          cfg_next.slot_time          = cfg_wdata[7:0];
                CFG_SAMPLE_DELAY:       cfg_next.sample_delay       = cfg_wdata[5:0];
                CFG_RECOVERY_TIME:      cfg_next.recovery_time      = cfg_wdata[7:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_time     <= RESET_LOW_TIME_DEF;
            cfg_reg.presence_wait_time <= PRESENCE_WAIT_TIME_DEF;
            cfg_reg.write_low_time     <= WRITE_LOW_TIME_DEF;
            cfg_reg.slot_time          <= SLOT_TIME_DEF;
            cfg_reg.sample_delay       <= SAMPLE_DELAY_DEF;
            cfg_reg.recovery_time      <= RECOVERY_TIME_DEF;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/owb_core.sv */
module owb_core
    import owb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  owb_cfg_t             cfg,
    input  logic                 step,
    input  logic [1:0]           opcode,
    input  logic [ByteWidth-1:0] write_data,
    input  logic                 line_level,
    output owb_res_t             res
);

    phase_t                 phase_reg, phase_next;
    logic [TickWidth-1:0]   tick_reg, tick_next;
    logic [BitIdxWidth-1:0] bit_reg, bit_next;
    logic [ByteWidth-1:0]   shift_reg, shift_next;
    op_t                    kind_reg, kind_next;
    logic [ByteWidth-1:0]   last_read_reg, last_read_next;

    logic [TickWidth-1:0]   tick_dec;
    logic [BitIdxWidth-1:0] bit_inc;
    logic                   done;
    logic                   rej;
    op_t                    op;

    assign op       = op_t'(opcode);
    assign tick_dec = (tick_reg != '0) ? tick_reg - 1'b1 : '0;
    assign bit_inc  = bit_reg + 1'b1;

    // Next-state logic for one item.
    always_comb begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        kind_next      = kind_reg;
        last_read_next = last_read_reg;
        done           = 1'b0;
        rej            = 1'b0;
        priority if (op == OP_TICK) begin
            priority if (phase_reg == PH_IDLE) begin
                phase_next = PH_IDLE;
            end else if (phase_reg == PH_PRES_FALL) begin
                if (!line_level) begin
                    phase_next = PH_PRES_RISE;
                    tick_next  = '0;
                end
            end else if (phase_reg == PH_PRES_RISE) begin
                if (line_level) begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    done       = 1'b1;
                end
            end else if (tick_dec != '0) begin
                tick_next = tick_dec;
            end else begin
                unique case (phase_reg)
                    PH_RST_LOW: begin
                        phase_next = PH_RST_WAIT;
                        tick_next  = TickWidth'(cfg.presence_wait_time);
                    end
                    PH_RST_WAIT: begin
                        phase_next = PH_PRES_FALL;
                        tick_next  = '0;
                    end
                    PH_WR_LOW: begin
                        phase_next = PH_WR_SLOT;
                        tick_next  = TickWidth'(cfg.slot_time);
                    end
                    PH_WR_SLOT: begin
                        shift_next = {1'b0, shift_reg[ByteWidth-1:1]};
                        bit_next   = bit_inc;
                        if (bit_inc >= BITS_PER_BYTE) begin
                            phase_next = PH_WR_RECOV;
                            tick_next  = TickWidth'(cfg.recovery_time);
                        end else begin
                            phase_next = PH_WR_REL;
                            tick_next  = TickWidth'(1);
                        end
                    end
                    PH_WR_REL: begin
                        phase_next = PH_WR_LOW;
                        tick_next  = TickWidth'(cfg.write_low_time);
                    end
                    PH_WR_RECOV: begin
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                        done       = 1'b1;
                    end
                    PH_RD_PULSE: begin
                        phase_next = PH_RD_DELAY;
                        tick_next  = TickWidth'(cfg.sample_delay);
                    end
                    PH_RD_DELAY: begin
                        shift_next = {line_level, shift_reg[ByteWidth-1:1]};
                        phase_next = PH_RD_SLOT;
                        tick_next  = TickWidth'(cfg.slot_time);
                    end
                    PH_RD_SLOT: begin
                        bit_next = bit_inc;
                        if (bit_inc >= BITS_PER_BYTE) begin
                            last_read_next = shift_reg;
                            phase_next     = PH_IDLE;
                            tick_next      = '0;
                            done           = 1'b1;
                        end else begin
                            phase_next = PH_RD_PULSE;
                            tick_next  = TickWidth'(1);
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                    end
                endcase
            end
        end else if (phase_reg != PH_IDLE) begin
            rej = 1'b1;
        end else begin
            kind_next = op;
            bit_next  = '0;
            priority if (op == OP_RESET) begin
                phase_next = PH_RST_LOW;
                tick_next  = cfg.reset_low_time;
            end else if (op == OP_WRITE) begin
                shift_next = write_data;
                phase_next = PH_WR_LOW;
                tick_next  = TickWidth'(cfg.write_low_time);
            end else begin
                shift_next = '0;
                phase_next = PH_RD_PULSE;
                tick_next  = TickWidth'(1);
            end
        end
    end

    // Result fields follow the state after the item.
    always_comb begin
        unique case (phase_next)
            PH_RST_LOW, PH_WR_LOW, PH_RD_PULSE: res.drive_low = 1'b1;
            PH_WR_SLOT:                         res.drive_low = ~shift_next[0];
            default:                            res.drive_low = 1'b0;
        endcase
        res.busy_res  = (phase_next != PH_IDLE);
        res.done_res  = done;
        res.read_data = last_read_next;
        res.rejected  = rej;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            kind_reg      <= OP_TICK;
            last_read_reg <= '0;
        end else if (step) begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            kind_reg      <= kind_next;
            last_read_reg <= last_read_next;
        end
    end

    // A write or read never counts past the last bit of the byte.
    a_bit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_reg <= BITS_PER_BYTE)
        else $error("bit index ran past the byte");

    // Write phases only occur under a write command.
    a_write_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_WR_LOW || phase_reg == PH_WR_SLOT ||
         phase_reg == PH_WR_REL || phase_reg == PH_WR_RECOV) |-> kind_reg == OP_WRITE)
        else $error("write phase outside a write command");

    // Completing a command always leaves the sequencer idle.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && done) |=> phase_reg == PH_IDLE)
        else $error("command completed but sequencer not idle");

endmodule
